// File: hw/rtl/vmx_pkg.sv
// ----------------------------------------------------------------------------
// vmx_pkg
// shared types, operation codes and constants of the vm execute unit
// ----------------------------------------------------------------------------
package vmx_pkg;

    localparam int NUM_REGS      = 16;
    localparam int REG_W         = 4;
    localparam int DATA_W        = 32;
    localparam int IMM_W         = 20;
    localparam int MEM_WORDS_DEF = 8192;
    localparam int IN_TDATA_W    = 40;
    localparam int OUT_TDATA_W   = 40;

    localparam logic [REG_W-1:0]  PC_INDEX  = 4'd15;
    localparam logic [REG_W-1:0]  SP_INDEX  = 4'd14;
    localparam logic [DATA_W-1:0] STACK_TOP = 32'h0000_1fff;

    typedef logic [3:0] mode_t;
    localparam mode_t MODE_END  = 4'd0;
    localparam mode_t MODE_NOP  = 4'd1;
    localparam mode_t MODE_PUSH = 4'd2;
    localparam mode_t MODE_POP  = 4'd3;
    localparam mode_t MODE_MOV  = 4'd4;
    localparam mode_t MODE_LDR  = 4'd5;
    localparam mode_t MODE_STR  = 4'd6;
    localparam mode_t MODE_ADD  = 4'd7;
    localparam mode_t MODE_SUB  = 4'd8;
    localparam mode_t MODE_CMP  = 4'd9;
    localparam mode_t MODE_JMP  = 4'd10;
    localparam mode_t MODE_NOT  = 4'd11;
    localparam mode_t MODE_AND  = 4'd12;
    localparam mode_t MODE_OR   = 4'd13;
    localparam mode_t MODE_XOR  = 4'd14;

    typedef logic [1:0] form_t;
    localparam form_t FORM_IMM = 2'd0;
    localparam form_t FORM_REG = 2'd1;
    localparam form_t FORM_LIT = 2'd2;

    typedef logic [1:0] fault_t;
    localparam fault_t FAULT_NONE  = 2'd0;
    localparam fault_t FAULT_STACK = 2'd1;
    localparam fault_t FAULT_ADDR  = 2'd2;

    typedef struct packed {
        logic n;
        logic c;
        logic v;
        logic z;
    } flags_t;

    typedef struct packed {
        logic [DATA_W-1:0] result;
        logic              wr_d;
        flags_t            flags;
    } alu_out_t;

    function automatic logic uses_operand(input mode_t m);
        logic u;
        case (m) inside
            MODE_PUSH, MODE_MOV, MODE_ADD, MODE_SUB, MODE_CMP,
            MODE_JMP, MODE_AND, MODE_OR, MODE_XOR: u = 1'b1;
            default:                               u = 1'b0;
        endcase
        return u;
    endfunction

endpackage

// File: hw/rtl/vmx_ram.sv
// ----------------------------------------------------------------------------
// vmx_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module vmx_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/vmx_regfile.sv
// ----------------------------------------------------------------------------
// vmx_regfile
// two read port register file built from two ram copies, with reset valid
// bits and a bypass for a write landing on the read edge
// ----------------------------------------------------------------------------
module vmx_regfile (
    input  logic                       clk,
    input  logic                       rstn,
    input  logic                       rd_en,
    input  logic [vmx_pkg::REG_W-1:0]  rd_a_idx,
    input  logic [vmx_pkg::REG_W-1:0]  rd_b_idx,
    input  logic                       wr_en,
    input  logic [vmx_pkg::REG_W-1:0]  wr_idx,
    input  logic [vmx_pkg::DATA_W-1:0] wr_data,
    output logic [vmx_pkg::DATA_W-1:0] rd_a_data,
    output logic [vmx_pkg::DATA_W-1:0] rd_b_data
);
    import vmx_pkg::*;

    logic [NUM_REGS-1:0] valid_reg;
    logic [NUM_REGS-1:0] valid_next;
    logic [DATA_W-1:0]   q_a;
    logic [DATA_W-1:0]   q_b;
    logic                vld_a_reg;
    logic                vld_b_reg;
    logic                byp_a_reg;
    logic                byp_b_reg;
    logic [DATA_W-1:0]   byp_data_reg;

    vmx_ram #(.WIDTH(DATA_W), .DEPTH(NUM_REGS)) u_ram_a (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_idx),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_a_idx),
        .rdata (q_a)
    );

    vmx_ram #(.WIDTH(DATA_W), .DEPTH(NUM_REGS)) u_ram_b (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_idx),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_b_idx),
        .rdata (q_b)
    );

    always_comb begin
        valid_next = valid_reg;
        if (wr_en) begin
            valid_next[wr_idx] = 1'b1;
        end
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk) begin
        if (rd_en) begin
            vld_a_reg    <= valid_reg[rd_a_idx];
            vld_b_reg    <= valid_reg[rd_b_idx];
            byp_a_reg    <= wr_en && (wr_idx == rd_a_idx);
            byp_b_reg    <= wr_en && (wr_idx == rd_b_idx);
            byp_data_reg <= wr_data;
        end
    end

    assign rd_a_data = byp_a_reg ? byp_data_reg : (vld_a_reg ? q_a : '0);
    assign rd_b_data = byp_b_reg ? byp_data_reg : (vld_b_reg ? q_b : '0);

endmodule

// File: hw/rtl/vmx_alu.sv
// ----------------------------------------------------------------------------
// vmx_alu
// result value, destination write and flag update of one instruction
// ----------------------------------------------------------------------------
module vmx_alu (
    input  vmx_pkg::mode_t             mode,
    input  logic [vmx_pkg::DATA_W-1:0] dv,
    input  logic [vmx_pkg::DATA_W-1:0] op,
    input  logic [vmx_pkg::DATA_W-1:0] mem_data,
    input  logic                       taken,
    input  vmx_pkg::flags_t            flags_in,
    output vmx_pkg::alu_out_t          alu_out
);
    import vmx_pkg::*;

    logic [DATA_W:0]   sum;
    logic [DATA_W-1:0] diff;
    logic [DATA_W-1:0] logic_r;

    always_comb begin
        sum  = {1'b0, dv} + {1'b0, op};
        diff = dv - op;
        case (mode)
            MODE_AND: logic_r = dv & op;
            MODE_OR:  logic_r = dv | op;
            default:  logic_r = dv ^ op;
        endcase

        alu_out.result = '0;
        alu_out.wr_d   = 1'b0;
        alu_out.flags  = flags_in;
        unique case (mode) inside
            MODE_POP, MODE_LDR: begin
                alu_out.result = mem_data;
                alu_out.wr_d   = 1'b1;
            end
            MODE_MOV: begin
                alu_out.result = op;
                alu_out.wr_d   = 1'b1;
            end
            MODE_ADD: begin
                alu_out.result  = sum[DATA_W-1:0];
                alu_out.wr_d    = 1'b1;
                alu_out.flags.n = sum[DATA_W-1];
                alu_out.flags.z = (sum[DATA_W-1:0] == '0);
                alu_out.flags.c = sum[DATA_W];
                alu_out.flags.v = (dv[DATA_W-1] == op[DATA_W-1])
                                  && (sum[DATA_W-1] != dv[DATA_W-1]);
            end
            MODE_SUB, MODE_CMP: begin
                if (mode == MODE_SUB) begin
                    alu_out.result = diff;
                    alu_out.wr_d   = 1'b1;
                end
                alu_out.flags.n = diff[DATA_W-1];
                alu_out.flags.z = (diff == '0);
                alu_out.flags.c = (op > dv);
                alu_out.flags.v = (dv[DATA_W-1] != op[DATA_W-1])
                                  && (op[DATA_W-1] == diff[DATA_W-1]);
            end
            MODE_JMP: begin
                alu_out.result = taken ? op : '0;
            end
            MODE_NOT: begin
                alu_out.result = ~dv;
                alu_out.wr_d   = 1'b1;
            end
            MODE_AND, MODE_OR, MODE_XOR: begin
                alu_out.result  = logic_r;
                alu_out.wr_d    = 1'b1;
                alu_out.flags.n = logic_r[DATA_W-1];
                alu_out.flags.z = (logic_r == '0);
                alu_out.flags.c = 1'b0;
                alu_out.flags.v = 1'b0;
            end
            default: begin
                alu_out.result = '0;
            end
        endcase
    end

endmodule

// File: hw/rtl/vm_execute_unit_top.sv
// ----------------------------------------------------------------------------
// vm_execute_unit_top
// executes one decoded instruction per beat against a register file, a word
// memory, nzcv flags and a run bit
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | instruction fields in s_tdata
//  m_      | out | m_tvalid/m_tready  | result value, flags, fault, halted
//
//  the register file is read at the accepting edge, the word memory from the
//  read stage registers, and execute writes back into the output register
//  from the execute stage registers once that register is empty or being taken
//  a new beat is taken on the cycle the previous one writes back, so only one
//  beat is in the read or execute stage at a time
//  reset clears pc, sp, flags and the register valid bits and sets the run bit to one
//  a full output register that is not taken holds the write back stage and
//  with it the input side
// ----------------------------------------------------------------------------
module vm_execute_unit_top #(
    parameter int MEM_WORDS = vmx_pkg::MEM_WORDS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // mode[3:0], operand_form[5:4], target_reg[9:6], src_reg[13:10],
    // immediate[33:14], jump_taken[34], zero pad
    input  logic [vmx_pkg::IN_TDATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // result_value[31:0], negative_flag[32], carry_flag[33],
    // overflow_flag[34], zero_flag[35], fault[37:36], halted[38], zero pad
    output logic [vmx_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import vmx_pkg::*;

    localparam int MEM_AW = $clog2(MEM_WORDS);
    localparam logic [DATA_W-1:0] MEM_LIMIT = DATA_W'(MEM_WORDS);

    // handshake
    logic s_fire;
    logic s3_done;

    // architectural state
    logic [DATA_W-1:0] pc_reg, pc_next;
    logic [DATA_W-1:0] sp_reg, sp_next;
    flags_t            flags_reg, flags_next;
    logic              run_reg, run_next;

    // read stage
    logic              s2_valid_reg;
    mode_t             s2_mode_reg;
    form_t             s2_form_reg;
    logic [REG_W-1:0]  s2_d_reg;
    logic [REG_W-1:0]  s2_s_reg;
    logic [IMM_W-1:0]  s2_imm_reg;
    logic              s2_taken_reg;
    logic [DATA_W-1:0] rf_a_data;
    logic [DATA_W-1:0] rf_b_data;
    logic [DATA_W-1:0] s2_dv;
    logic [DATA_W-1:0] s2_sv;
    logic [DATA_W-1:0] s2_sp_m1;
    logic              s2_uses;
    logic              s2_fetch;
    logic [DATA_W-1:0] s2_op_pre;
    fault_t            s2_fault;
    logic [MEM_AW-1:0] mem_raddr;

    // execute stage
    logic              s3_valid_reg, s3_valid_next;
    mode_t             s3_mode_reg;
    logic [REG_W-1:0]  s3_d_reg;
    logic              s3_taken_reg;
    logic [DATA_W-1:0] s3_dv_reg;
    logic [DATA_W-1:0] s3_sv_reg;
    logic [DATA_W-1:0] s3_op_pre_reg;
    logic              s3_fetch_reg;
    fault_t            s3_fault_reg;
    logic [DATA_W-1:0] mem_q;
    logic [DATA_W-1:0] s3_op;
    alu_out_t          alu_out;
    logic              s3_ok;
    logic [DATA_W-1:0] s3_result;
    logic              rf_we;
    logic              mem_we;
    logic [MEM_AW-1:0] mem_waddr;
    logic [DATA_W-1:0] mem_wdata;

    // output register
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;

    assign s3_done  = s3_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready = !s2_valid_reg && (!s3_valid_reg || s3_done);
    assign s_fire   = s_tvalid && s_tready;

    vmx_regfile u_regfile (
        .clk       (aclk),
        .rstn      (aresetn),
        .rd_en     (s_fire),
        .rd_a_idx  (s_tdata[9:6]),
        .rd_b_idx  (s_tdata[13:10]),
        .wr_en     (rf_we),
        .wr_idx    (s3_d_reg),
        .wr_data   (s3_result),
        .rd_a_data (rf_a_data),
        .rd_b_data (rf_b_data)
    );

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s2_mode_reg  <= s_tdata[3:0];
            s2_form_reg  <= s_tdata[5:4];
            s2_d_reg     <= s_tdata[9:6];
            s2_s_reg     <= s_tdata[13:10];
            s2_imm_reg   <= s_tdata[33:14];
            s2_taken_reg <= s_tdata[34];
        end
    end

    // read stage: operands, fault checks, memory read address
    always_comb begin
        s2_dv = (s2_d_reg == PC_INDEX) ? pc_reg :
                (s2_d_reg == SP_INDEX) ? sp_reg : rf_a_data;
        s2_sv = (s2_s_reg == PC_INDEX) ? pc_reg :
                (s2_s_reg == SP_INDEX) ? sp_reg : rf_b_data;
        s2_sp_m1  = sp_reg - DATA_W'(1);
        s2_uses   = uses_operand(s2_mode_reg);
        s2_fetch  = s2_uses && (s2_form_reg == FORM_LIT);
        s2_op_pre = (s2_uses && (s2_form_reg == FORM_REG)) ? s2_sv
                                                            : DATA_W'(s2_imm_reg);
        s2_fault = FAULT_NONE;
        if (run_reg) begin
            if (s2_fetch && (pc_reg >= MEM_LIMIT)) begin
                s2_fault = FAULT_ADDR;
            end else begin
                case (s2_mode_reg)
                    MODE_PUSH: begin
                        if (sp_reg > STACK_TOP) begin
                            s2_fault = FAULT_STACK;
                        end else if (sp_reg >= MEM_LIMIT) begin
                            s2_fault = FAULT_ADDR;
                        end
                    end
                    MODE_POP: begin
                        if ((sp_reg == '0) || (s2_sp_m1 > STACK_TOP)) begin
                            s2_fault = FAULT_STACK;
                        end else if (s2_sp_m1 >= MEM_LIMIT) begin
                            s2_fault = FAULT_ADDR;
                        end
                    end
                    MODE_LDR: begin
                        if (s2_sv >= MEM_LIMIT) begin
                            s2_fault = FAULT_ADDR;
                        end
                    end
                    MODE_STR: begin
                        if (s2_dv >= MEM_LIMIT) begin
                            s2_fault = FAULT_ADDR;
                        end
                    end
                    default: begin
                        s2_fault = FAULT_NONE;
                    end
                endcase
            end
        end
        if (s2_fetch) begin
            mem_raddr = pc_reg[MEM_AW-1:0];
        end else if (s2_mode_reg == MODE_POP) begin
            mem_raddr = s2_sp_m1[MEM_AW-1:0];
        end else begin
            mem_raddr = s2_sv[MEM_AW-1:0];
        end
    end

    vmx_ram #(.WIDTH(DATA_W), .DEPTH(MEM_WORDS)) u_word_mem (
        .clk   (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (s2_valid_reg),
        .raddr (mem_raddr),
        .rdata (mem_q)
    );

    always_ff @(posedge aclk) begin
        if (s2_valid_reg) begin
            s3_mode_reg   <= s2_mode_reg;
            s3_d_reg      <= s2_d_reg;
            s3_taken_reg  <= s2_taken_reg;
            s3_dv_reg     <= s2_dv;
            s3_sv_reg     <= s2_sv;
            s3_op_pre_reg <= s2_op_pre;
            s3_fetch_reg  <= s2_fetch;
            s3_fault_reg  <= s2_fault;
        end
    end

    // execute and write back
    assign s3_op = s3_fetch_reg ? mem_q : s3_op_pre_reg;

    vmx_alu u_alu (
        .mode     (s3_mode_reg),
        .dv       (s3_dv_reg),
        .op       (s3_op),
        .mem_data (mem_q),
        .taken    (s3_taken_reg),
        .flags_in (flags_reg),
        .alu_out  (alu_out)
    );

    always_comb begin
        s3_ok      = run_reg && (s3_fault_reg == FAULT_NONE);
        s3_result  = s3_ok ? alu_out.result : '0;
        pc_next    = pc_reg;
        sp_next    = sp_reg;
        flags_next = flags_reg;
        run_next   = run_reg;
        rf_we      = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = sp_reg[MEM_AW-1:0];
        mem_wdata  = s3_op;
        if (s3_done && run_reg) begin
            if (!s3_ok) begin
                run_next = 1'b0;
            end else begin
                if (s3_fetch_reg) begin
                    pc_next = pc_reg + DATA_W'(1);
                end
                flags_next = alu_out.flags;
                case (s3_mode_reg)
                    MODE_END: begin
                        run_next = 1'b0;
                    end
                    MODE_PUSH: begin
                        mem_we  = 1'b1;
                        sp_next = sp_reg + DATA_W'(1);
                    end
                    MODE_POP: begin
                        mem_we    = 1'b1;
                        mem_waddr = s2_sp_m1[MEM_AW-1:0];
                        mem_wdata = '0;
                        sp_next   = s2_sp_m1;
                    end
                    MODE_STR: begin
                        mem_we    = 1'b1;
                        mem_waddr = s3_dv_reg[MEM_AW-1:0];
                        mem_wdata = s3_sv_reg;
                    end
                    MODE_JMP: begin
                        if (s3_taken_reg) begin
                            pc_next = s3_op;
                        end
                    end
                    default: begin
                        mem_we = 1'b0;
                    end
                endcase
                if (alu_out.wr_d) begin
                    rf_we = 1'b1;
                    if (s3_d_reg == PC_INDEX) begin
                        pc_next = alu_out.result;
                    end
                    if (s3_d_reg == SP_INDEX) begin
                        sp_next = alu_out.result;
                    end
                end
            end
        end
    end

    always_comb begin
        if (s2_valid_reg) begin
            s3_valid_next = 1'b1;
        end else if (s3_done) begin
            s3_valid_next = 1'b0;
        end else begin
            s3_valid_next = s3_valid_reg;
        end
        if (s3_done) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg       <= '0;
            sp_reg       <= '0;
            flags_reg    <= '0;
            run_reg      <= 1'b1;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            pc_reg       <= pc_next;
            sp_reg       <= sp_next;
            flags_reg    <= flags_next;
            run_reg      <= run_next;
            s2_valid_reg <= s_fire;
            s3_valid_reg <= s3_valid_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s3_done) begin
            m_tdata_reg <= {1'b0, !run_next,
                            (run_reg ? s3_fault_reg : FAULT_NONE),
                            flags_next.z, flags_next.v, flags_next.c, flags_next.n,
                            s3_result};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_accept_enters_read: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> s2_valid_reg)
        else $error("accepted beat did not enter the read stage");

    a_single_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s2_valid_reg |-> !s3_valid_reg)
        else $error("read and execute stages occupied together");

    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        !run_reg |=> !run_reg)
        else $error("run bit set again after halt");

    a_fault_halts: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && (m_tdata_reg[37:36] != FAULT_NONE)) |-> m_tdata_reg[38])
        else $error("fault reported without halt");

endmodule
